// File: rtl/module_power_key_sequencer_top_assert.svh
// Assertion macros for the power-key sequencer top level.
// Depends on nothing; included by module_power_key_sequencer_top.sv.
`ifndef MODULE_POWER_KEY_SEQUENCER_TOP_ASSERT_SVH
`define MODULE_POWER_KEY_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication under an active-low reset.
`define PKS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("power key sequencer assertion failed");
// Next-cycle implication under an active-low reset.
`define PKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("power key sequencer assertion failed");
`else
`define PKS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PKS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/pks_pkg.sv
// Shared types and constants of the power-key sequencer.
// Used by the channel interfaces and the top level; depends on nothing.
package pks_pkg;

	localparam int MODULES = 4;
	localparam int TICK_W = 16;
	localparam int IVL_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [MODULES-1:0] MOD_ALL = {MODULES{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT = 2'd2;

	// Register reset values.
	localparam logic [TICK_W-1:0] PULSE_TICKS_RST = 16'd2000;
	localparam logic [IVL_W-1:0] POLL_INTERVAL_RST = 10'd10;
	localparam logic [TICK_W-1:0] POLL_LIMIT_RST = 16'd800;

	// Input item function codes.
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PULSE = 3'b010,
		PH_POLL = 3'b100
	} phase_t;

endpackage

// File: rtl/pks_req_if.sv
// Input channel of the power-key sequencer: valid, ready and one input item.
// Depends on pks_pkg.
interface pks_req_if;
	logic valid;
	logic ready;
	logic func;
	logic [pks_pkg::MODULES-1:0] module_mask;
	logic turn_on;
	logic [pks_pkg::MODULES-1:0] monitor_bits;

	modport source (output valid, func, module_mask, turn_on, monitor_bits, input ready);
	modport sink (input valid, func, module_mask, turn_on, monitor_bits, output ready);
endinterface

// File: rtl/pks_rsp_if.sv
// Result channel of the power-key sequencer: valid, ready and one result item.
// Depends on pks_pkg.
interface pks_rsp_if;
	logic valid;
	logic ready;
	logic [pks_pkg::MODULES-1:0] power_drive;
	logic busy_res;
	logic [pks_pkg::MODULES-1:0] pending_mask;
	logic [pks_pkg::MODULES-1:0] powered_mask;
	logic done_res;
	logic start_ignored;

	modport source (output valid, power_drive, busy_res, pending_mask, powered_mask,
		done_res, start_ignored, input ready);
	modport sink (input valid, power_drive, busy_res, pending_mask, powered_mask,
		done_res, start_ignored, output ready);
endinterface

// File: rtl/pks_cfg_if.sv
// Configuration write channel of the power-key sequencer: valid, ready, index, data.
// Depends on pks_pkg.
interface pks_cfg_if;
	logic valid;
	logic ready;
	logic [pks_pkg::CFG_IDX_W-1:0] index;
	logic [pks_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/module_power_key_sequencer_top.sv
// Top level of the power-key sequencer: sequence state, registers and result register.
// Depends on pks_pkg, the three channel interfaces and the assertion macro header.
//
// Usage:
// The req channel carries one transaction per start request or per millisecond
// tick. A start names a module mask and a target state; modules whose monitor
// pin already shows the target are dropped, the rest get their power pin held
// for pulse_ticks ticks, then the monitor pins are polled every
// poll_interval_ticks ticks, at most poll_limit times. Every req transaction
// yields exactly one rsp transaction showing the state after that item, with
// done_res on the item that finishes a sequence and start_ignored on a start
// that arrived while busy. The cfg channel writes the three registers and is
// always ready. Rsp valid rises in the cycle after req acceptance; one item
// is accepted every cycle while the receiver takes results: the only storage
// between the sides is the result register, which holds if the receiver
// stalls, and req ready then drops until the pending result is taken. Reset
// clears the sequence state, empties the result register, loads the defaults.
`include "module_power_key_sequencer_top_assert.svh"

module module_power_key_sequencer_top (
	input logic clk,
	input logic arst_n,
	pks_cfg_if.sink cfg,
	pks_req_if.sink req,
	pks_rsp_if.source rsp
);
	import pks_pkg::*;

	// Configuration registers.
	logic [TICK_W-1:0] pulse_ticks_q;
	logic [IVL_W-1:0] poll_interval_q;
	logic [TICK_W-1:0] poll_limit_q;

	// Sequence state.
	phase_t phase_q, phase_d;
	logic target_on_q, target_on_d;
	logic [MODULES-1:0] pending_q, pending_d;
	logic [MODULES-1:0] drive_q, drive_d;
	logic [MODULES-1:0] powered_q, powered_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic [TICK_W-1:0] polls_q, polls_d;
	logic done_d, ignored_d;

	// Result register.
	logic out_valid_q;
	logic done_q, ignored_q;

	logic req_fire;
	logic [TICK_W-1:0] tick_inc;
	logic [MODULES-1:0] reached;
	logic [MODULES-1:0] pend_left;
	logic [TICK_W-1:0] polls_dec;

	assign cfg.ready = 1'b1;

	// A new item enters whenever the result register is empty or being drained.
	assign req.ready = !out_valid_q || rsp.ready;
	assign req_fire = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks_q <= PULSE_TICKS_RST;
			poll_interval_q <= POLL_INTERVAL_RST;
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PULSE_TICKS: pulse_ticks_q <= cfg.data;
				REG_POLL_INTERVAL: poll_interval_q <= cfg.data[IVL_W-1:0];
				REG_POLL_LIMIT: poll_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign tick_inc = tick_q + TICK_W'(1);
	assign polls_dec = polls_q - TICK_W'(1);
	assign reached = target_on_q ? (pending_q & req.monitor_bits)
		: (pending_q & ~req.monitor_bits);
	assign pend_left = pending_q & ~reached;

	always_comb begin
		phase_d = phase_q;
		target_on_d = target_on_q;
		pending_d = pending_q;
		drive_d = drive_q;
		powered_d = powered_q;
		tick_d = tick_q;
		polls_d = polls_q;
		done_d = 1'b0;
		ignored_d = 1'b0;
		if (req.func == FUNC_START) begin
			if (phase_q != PH_IDLE) begin
				ignored_d = 1'b1;
			end else begin
				target_on_d = req.turn_on;
				pending_d = req.turn_on ? (req.module_mask & ~req.monitor_bits)
					: (req.module_mask & req.monitor_bits);
				drive_d = pending_d;
				tick_d = '0;
				polls_d = '0;
				phase_d = PH_PULSE;
			end
		end else begin
			unique case (phase_q)
				PH_PULSE: begin
					tick_d = tick_inc;
					if (tick_inc >= pulse_ticks_q) begin
						drive_d = '0;
						tick_d = '0;
						polls_d = poll_limit_q;
						if (pending_q == '0 || poll_limit_q == '0) begin
							done_d = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_POLL;
						end
					end
				end
				PH_POLL: begin
					tick_d = tick_inc;
					if (tick_inc >= {{(TICK_W-IVL_W){1'b0}}, poll_interval_q}) begin
						tick_d = '0;
						powered_d = target_on_q ? (powered_q | reached)
							: (powered_q & ~reached);
						pending_d = pend_left;
						polls_d = polls_dec;
						if (pend_left == '0 || polls_dec == '0) begin
							done_d = 1'b1;
							phase_d = PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			target_on_q <= 1'b0;
			pending_q <= '0;
			drive_q <= '0;
			powered_q <= '0;
			tick_q <= '0;
			polls_q <= '0;
			out_valid_q <= 1'b0;
			done_q <= 1'b0;
			ignored_q <= 1'b0;
		end else begin
			if (req_fire) begin
				phase_q <= phase_d;
				target_on_q <= target_on_d;
				pending_q <= pending_d;
				drive_q <= drive_d;
				powered_q <= powered_d;
				tick_q <= tick_d;
				polls_q <= polls_d;
				done_q <= done_d;
				ignored_q <= ignored_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result shows the sequence state left by the last accepted item.
	assign rsp.valid = out_valid_q;
	assign rsp.power_drive = drive_q;
	assign rsp.busy_res = (phase_q != PH_IDLE);
	assign rsp.pending_mask = pending_q;
	assign rsp.powered_mask = powered_q;
	assign rsp.done_res = done_q;
	assign rsp.start_ignored = ignored_q;

	// A finished sequence leaves the block idle.
	`PKS_ASSERT_IMP(a_done_idle, clk, arst_n, out_valid_q && done_q, phase_q == PH_IDLE)
	// Power pins are only driven during the pulse wait.
	`PKS_ASSERT_IMP(a_drive_pulse, clk, arst_n, drive_q != '0, phase_q == PH_PULSE)
	// A start accepted while busy is reported as ignored on the next result.
	`PKS_ASSERT_NEXT(a_start_busy, clk, arst_n,
		req_fire && req.func == FUNC_START && phase_q != PH_IDLE,
		out_valid_q && ignored_q)
	// Done and ignored never appear on the same result.
	`PKS_ASSERT_IMP(a_done_excl, clk, arst_n, out_valid_q && done_q, !ignored_q)

endmodule
